// ===== rtl/dgp_pkg.sv =====
`timescale 1ns / 1ps
package dgp_pkg;

    // Angle limits in rad/8192: an error magnitude above PI_Q lies past pi
    localparam int PI_Q    = 25735;
    localparam int TWOPI_Q = 51472;

    localparam int SQRT_STEPS   = 21;
    localparam int CORDIC_STEPS = 20;

    // Bearing accumulator scale is rad * 2^24
    localparam logic signed [27:0] HALF_PI_F = 28'sd26353589;

    localparam logic [23:0] ATAN_TAB [CORDIC_STEPS] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
        24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
        24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024,
        24'd512, 24'd256, 24'd128, 24'd64, 24'd32
    };

    typedef enum logic [2:0] {
        MODE_STOP    = 3'd0,
        MODE_ROT_CCW = 3'd1,
        MODE_ROT_CW  = 3'd2,
        MODE_FWD     = 3'd3,
        MODE_ARC_L   = 3'd4,
        MODE_ARC_R   = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MAX_SPEED  = 3'd0,
        CFG_ROT_GAIN   = 3'd1,
        CFG_HEAD_GAIN  = 3'd2,
        CFG_DIST_GAIN  = 3'd3,
        CFG_SIN_GAIN   = 3'd4,
        CFG_COS_GAIN   = 3'd5,
        CFG_HEAD_WIN   = 3'd6
    } t_cfg_idx;

    // Per-item terms that ride beside the root and bearing pipelines
    typedef struct packed {
        logic                inpos;
        logic                stop;
        logic                rot_neg;
        logic [14:0]         rot_s;
        logic signed [15:0]  pa;
        logic                dy_neg;
        logic signed [18:0]  sterm;
        logic signed [18:0]  cterm;
    } t_side;

endpackage

// ===== rtl/dgp_sqrt.sv =====
`timescale 1ns / 1ps
module dgp_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [41:0] i_rad,
    output logic [20:0] o_root
);

    logic [41:0] r_v    [dgp_pkg::SQRT_STEPS];
    logic [20:0] r_root [dgp_pkg::SQRT_STEPS];
    logic [22:0] r_rem  [dgp_pkg::SQRT_STEPS];
    logic [41:0] n_v    [dgp_pkg::SQRT_STEPS];
    logic [20:0] n_root [dgp_pkg::SQRT_STEPS];
    logic [22:0] n_rem  [dgp_pkg::SQRT_STEPS];

    // One result bit per stage: bring in two radicand bits, try to subtract
    always_comb begin
        logic [41:0] v_src;
        logic [20:0] root_src;
        logic [22:0] rem_src;
        logic [24:0] rem_t;
        logic [24:0] test;
        for (int k = 0; k < dgp_pkg::SQRT_STEPS; k++) begin
            if (k == 0) begin
                v_src    = i_rad;
                root_src = '0;
                rem_src  = '0;
            end else begin
                v_src    = r_v[k-1];
                root_src = r_root[k-1];
                rem_src  = r_rem[k-1];
            end
            rem_t = {rem_src, v_src[41:40]};
            test  = {2'b00, root_src, 2'b01};
            if (rem_t >= test) begin
                n_rem[k]  = 23'(rem_t - test);
                n_root[k] = {root_src[19:0], 1'b1};
            end else begin
                n_rem[k]  = rem_t[22:0];
                n_root[k] = {root_src[19:0], 1'b0};
            end
            n_v[k] = {v_src[39:0], 2'b00};
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_root <= n_root;
            r_rem  <= n_rem;
        end
    end

    assign o_root = r_root[dgp_pkg::SQRT_STEPS-1];

endmodule

// ===== rtl/dgp_cordic.sv =====
`timescale 1ns / 1ps
module dgp_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [20:0] i_dx,
    input  logic signed [20:0] i_dy,
    output logic signed [16:0] o_av
);

    localparam int N = dgp_pkg::CORDIC_STEPS + 1;

    logic signed [23:0] r_x [N];
    logic signed [23:0] r_y [N];
    logic signed [27:0] r_z [N];
    logic               r_zero [N];
    logic signed [23:0] n_x [N];
    logic signed [23:0] n_y [N];
    logic signed [27:0] n_z [N];
    logic               n_zero [N];
    logic signed [27:0] z_rnd;

    // Stage 0 folds the left half plane, then one vectoring step per stage
    always_comb begin
        logic signed [23:0] x0;
        logic signed [23:0] y0;
        logic signed [23:0] xs;
        logic signed [23:0] ys;
        x0 = 24'(i_dx);
        y0 = 24'(i_dy);
        n_zero[0] = (i_dx == '0) && (i_dy == '0);
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_x[0] = y0;
                n_y[0] = -x0;
                n_z[0] = dgp_pkg::HALF_PI_F;
            end else begin
                n_x[0] = -y0;
                n_y[0] = x0;
                n_z[0] = -dgp_pkg::HALF_PI_F;
            end
        end else begin
            n_x[0] = x0;
            n_y[0] = y0;
            n_z[0] = '0;
        end
        for (int i = 1; i < N; i++) begin
            xs = r_x[i-1] >>> (i - 1);
            ys = r_y[i-1] >>> (i - 1);
            n_zero[i] = r_zero[i-1];
            if (r_y[i-1] > 0) begin
                n_x[i] = r_x[i-1] + ys;
                n_y[i] = r_y[i-1] - xs;
                n_z[i] = r_z[i-1] + $signed({4'b0000, dgp_pkg::ATAN_TAB[i-1]});
            end else begin
                n_x[i] = r_x[i-1] - ys;
                n_y[i] = r_y[i-1] + xs;
                n_z[i] = r_z[i-1] - $signed({4'b0000, dgp_pkg::ATAN_TAB[i-1]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_zero <= n_zero;
        end
    end

    // Round the angle to rad/8192, half up
    assign z_rnd = (r_z[N-1] + 28'sd1024) >>> 11;
    assign o_av  = r_zero[N-1] ? '0 : z_rnd[16:0];

endmodule

// ===== rtl/diff_drive_go_to_pose.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata 160 b: pose request
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata 40 b: wheel command
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index 3 b, i_cfg_data 15 b
//
// An item passes 27 register stages, 21 of them in the square root and bearing
// pipelines that run side by side. One item is taken every cycle while the
// output register is not waiting on i_m_axis_tready.
// Synchronous active-low reset clears the valid bits and loads default gains.
// The whole pipeline holds while the output register waits on i_m_axis_tready.
module diff_drive_go_to_pose (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // target_x, target_y, target_angle, tolerance, pose_x, pose_y, pose_angle,
    // sin_adjust, cos_adjust
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // left_speed, right_speed, drive_mode, in_position, zero pad
    output logic [39:0]  o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [14:0]  i_cfg_data
);

    localparam int DEPTH = 3 + dgp_pkg::SQRT_STEPS + 3;

    logic [14:0] r_max_speed, r_rot_gain, r_head_gain, r_dist_gain;
    logic [14:0] r_sin_gain, r_cos_gain, r_head_win;
    logic        en;
    logic [DEPTH-1:0] r_vld;

    // Write configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 15'd25682;
            r_rot_gain  <= 15'd2458;
            r_head_gain <= 15'd6519;
            r_dist_gain <= 15'd12288;
            r_sin_gain  <= 15'd1229;
            r_cos_gain  <= 15'd410;
            r_head_win  <= 15'd819;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dgp_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_data;
                dgp_pkg::CFG_ROT_GAIN:  r_rot_gain  <= i_cfg_data;
                dgp_pkg::CFG_HEAD_GAIN: r_head_gain <= i_cfg_data;
                dgp_pkg::CFG_DIST_GAIN: r_dist_gain <= i_cfg_data;
                dgp_pkg::CFG_SIN_GAIN:  r_sin_gain  <= i_cfg_data;
                dgp_pkg::CFG_COS_GAIN:  r_cos_gain  <= i_cfg_data;
                dgp_pkg::CFG_HEAD_WIN:  r_head_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance everything unless the output holds an untaken transfer
    assign en              = !r_vld[DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // Stage A: differences
    logic signed [19:0] tx, ty, px, py;
    logic signed [15:0] ta, pa, sadj, cadj;
    logic [15:0]        tol;
    assign tx   = i_s_axis_tdata[19:0];
    assign ty   = i_s_axis_tdata[39:20];
    assign ta   = i_s_axis_tdata[55:40];
    assign tol  = i_s_axis_tdata[71:56];
    assign px   = i_s_axis_tdata[91:72];
    assign py   = i_s_axis_tdata[111:92];
    assign pa   = i_s_axis_tdata[127:112];
    assign sadj = i_s_axis_tdata[143:128];
    assign cadj = i_s_axis_tdata[159:144];

    logic signed [20:0] r_a_dx, r_a_dy;
    logic signed [16:0] r_a_d;
    logic [15:0]        r_a_tol;
    logic signed [15:0] r_a_pa, r_a_sadj, r_a_cadj;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx   <= 21'(tx) - 21'(px);
            r_a_dy   <= 21'(ty) - 21'(py);
            r_a_d    <= 17'(ta) - 17'(pa);
            r_a_tol  <= tol;
            r_a_pa   <= pa;
            r_a_sadj <= sadj;
            r_a_cadj <= cadj;
        end
    end

    // Stage B: wrapped angle error, squares, obstacle terms
    logic [16:0]        b_m;
    logic               b_mbig;
    logic signed [17:0] b_w, b_dmin, b_da;
    logic [20:0]        b_adx, b_ady;
    logic signed [32:0] b_sp, b_cp;

    assign b_m    = r_a_d[16] ? 17'(-r_a_d) : 17'(r_a_d);
    assign b_mbig = b_m > 17'(dgp_pkg::PI_Q);
    assign b_w    = 18'(dgp_pkg::TWOPI_Q) - $signed({1'b0, b_m});
    assign b_dmin = ($signed({1'b0, b_m}) < b_w) ? $signed({1'b0, b_m}) : b_w;
    assign b_da   = ((r_a_d < 0 && b_mbig) || (r_a_d > 0 && !b_mbig)) ? -b_dmin : b_dmin;
    assign b_adx  = r_a_dx[20] ? 21'(-r_a_dx) : 21'(r_a_dx);
    assign b_ady  = r_a_dy[20] ? 21'(-r_a_dy) : 21'(r_a_dy);
    assign b_sp   = (33'(r_a_sadj) * $signed({18'd0, r_sin_gain}) + 33'sd2048) >>> 12;
    assign b_cp   = (33'(r_a_cadj) * $signed({18'd0, r_cos_gain}) + 33'sd2048) >>> 12;

    logic [16:0]        r_b_absda;
    logic               r_b_daneg, r_b_inpos;
    logic [40:0]        r_b_dxsq, r_b_dysq;
    logic signed [18:0] r_b_sterm, r_b_cterm;
    logic [15:0]        r_b_tol;
    logic signed [20:0] r_b_dx, r_b_dy;
    logic signed [15:0] r_b_pa;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_absda <= b_da[17] ? 17'(-b_da) : 17'(b_da);
            r_b_daneg <= b_da[17];
            r_b_inpos <= (b_adx < 21'(r_a_tol)) && (b_ady < 21'(r_a_tol));
            r_b_dxsq  <= 41'(b_adx * b_adx);
            r_b_dysq  <= 41'(b_ady * b_ady);
            r_b_sterm <= b_sp[18:0];
            r_b_cterm <= b_cp[18:0];
            r_b_tol   <= r_a_tol;
            r_b_dx    <= r_a_dx;
            r_b_dy    <= r_a_dy;
            r_b_pa    <= r_a_pa;
        end
    end

    // Stage C: radicand, stop test, rotate speed
    logic [31:0]        c_rp;
    logic [16:0]        c_rs;
    logic [14:0]        c_rot;
    dgp_pkg::t_side     c_side;

    assign c_rp  = 32'(r_rot_gain * r_b_absda) + 32'd4096;
    assign c_rs  = 17'(c_rp >> 13);
    assign c_rot = (c_rs < 17'(r_max_speed)) ? c_rs[14:0] : r_max_speed;

    always_comb begin
        c_side.inpos   = r_b_inpos;
        c_side.stop    = 31'(r_b_absda * 14'd10000) < 31'(r_b_tol * 10'd628);
        c_side.rot_neg = r_b_daneg;
        c_side.rot_s   = c_rot;
        c_side.pa      = r_b_pa;
        c_side.dy_neg  = r_b_dy[20];
        c_side.sterm   = r_b_sterm;
        c_side.cterm   = r_b_cterm;
    end

    logic [41:0]        r_c_sum;
    logic signed [20:0] r_c_dx, r_c_dy;
    dgp_pkg::t_side     r_c_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sum  <= 42'(r_b_dxsq) + 42'(r_b_dysq);
            r_c_dx   <= r_b_dx;
            r_c_dy   <= r_b_dy;
            r_c_side <= c_side;
        end
    end

    // Distance and bearing pipelines, with side terms delayed to match
    logic [20:0]        root_len;
    logic signed [16:0] av;
    dgp_pkg::t_side     r_side [dgp_pkg::SQRT_STEPS];

    dgp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_c_sum),
        .o_root (root_len)
    );

    dgp_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dx  (r_c_dx),
        .i_dy  (r_c_dy),
        .o_av  (av)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_c_side;
            for (int k = 1; k < dgp_pkg::SQRT_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stage F1: forward speed, heading error, window test
    dgp_pkg::t_side     f_side;
    logic [35:0]        f_fp;
    logic signed [17:0] f_av, f_pa, f_e;
    logic [17:0]        f_me;

    assign f_side = r_side[dgp_pkg::SQRT_STEPS-1];
    assign f_fp   = 36'(r_dist_gain * root_len) + 36'd2048;
    assign f_av   = 18'(av);
    assign f_pa   = 18'(f_side.pa);
    assign f_e    = f_av - f_pa;
    assign f_me   = f_e[17] ? 18'(-f_e) : 18'(f_e);

    logic [23:0]    r_f1_fwd;
    logic [17:0]    r_f1_me;
    logic           r_f1_inwin, r_f1_arcl;
    dgp_pkg::t_side r_f1_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_fwd   <= f_fp[35:12];
            r_f1_me    <= f_me;
            r_f1_inwin <= (f_pa >= f_av - $signed({3'b000, r_head_win}))
                       && (f_pa <= f_av + $signed({3'b000, r_head_win}))
                       && !f_side.dy_neg;
            r_f1_arcl  <= ((f_av > f_pa) && !(f_me > 18'(dgp_pkg::PI_Q)))
                       || ((f_av < f_pa) && (f_me > 18'(dgp_pkg::PI_Q)));
            r_f1_side  <= f_side;
        end
    end

    // Stage F2: turn speed and limited forward speed
    logic [33:0] g_dp;
    logic [20:0] g_ds;

    assign g_dp = 34'(r_f1_me * r_head_gain) + 34'd4096;
    assign g_ds = g_dp[33:13];

    logic [14:0]    r_f2_ds, r_f2_fmin;
    logic [23:0]    r_f2_fwd;
    logic           r_f2_inwin, r_f2_arcl;
    dgp_pkg::t_side r_f2_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_ds    <= (g_ds < 21'(r_max_speed)) ? g_ds[14:0] : r_max_speed;
            r_f2_fmin  <= (r_f1_fwd < 24'(r_max_speed)) ? r_f1_fwd[14:0] : r_max_speed;
            r_f2_fwd   <= r_f1_fwd;
            r_f2_inwin <= r_f1_inwin;
            r_f2_arcl  <= r_f1_arcl;
            r_f2_side  <= r_f1_side;
        end
    end

    // Stage F3: wheel speeds and mode into the output register
    function automatic logic signed [15:0] sat(input logic signed [19:0] v,
                                                input logic signed [19:0] lo,
                                                input logic signed [19:0] hi);
        logic signed [19:0] t;
        t = (v > hi) ? hi : v;
        t = (t < lo) ? lo : t;
        return t[15:0];
    endfunction

    logic [24:0]        h_sum;
    logic [14:0]        h_hi, h_lo;
    logic signed [19:0] h_lim, h_lo3, h_hi3, h_fv;
    logic signed [15:0] n_left, n_right;
    dgp_pkg::t_mode     n_mode;

    assign h_sum = 25'(r_f2_ds) + 25'(r_f2_fwd);
    assign h_hi  = (h_sum < 25'(r_max_speed)) ? h_sum[14:0] : r_max_speed;
    assign h_lo  = (h_hi > r_f2_ds) ? 15'(h_hi - r_f2_ds) : '0;
    assign h_lim = $signed({5'd0, r_max_speed});
    assign h_lo3 = $signed({6'd0, h_lo[14:1]}) - 20'(r_f2_side.sterm);
    assign h_hi3 = r_f2_arcl ? $signed({6'd0, h_hi[14:1]}) + 20'(r_f2_side.cterm)
                             : $signed({6'd0, h_hi[14:1]}) - 20'(r_f2_side.cterm);
    assign h_fv  = $signed({5'd0, r_f2_fmin}) - 20'(r_f2_side.sterm);

    always_comb begin
        if (r_f2_side.inpos) begin
            if (r_f2_side.stop) begin
                n_left  = '0;
                n_right = '0;
                n_mode  = dgp_pkg::MODE_STOP;
            end else if (r_f2_side.rot_neg) begin
                n_left  = -$signed({1'b0, r_f2_side.rot_s});
                n_right = $signed({1'b0, r_f2_side.rot_s});
                n_mode  = dgp_pkg::MODE_ROT_CCW;
            end else begin
                n_left  = $signed({1'b0, r_f2_side.rot_s});
                n_right = -$signed({1'b0, r_f2_side.rot_s});
                n_mode  = dgp_pkg::MODE_ROT_CW;
            end
        end else if (r_f2_inwin) begin
            n_left  = sat(h_fv, '0, h_lim);
            n_right = n_left;
            n_mode  = dgp_pkg::MODE_FWD;
        end else if (r_f2_arcl) begin
            n_left  = sat(h_lo3, -h_lim, h_lim);
            n_right = sat(h_hi3, -h_lim, h_lim);
            n_mode  = dgp_pkg::MODE_ARC_L;
        end else begin
            n_left  = sat(h_hi3, -h_lim, h_lim);
            n_right = sat(h_lo3, -h_lim, h_lim);
            n_mode  = dgp_pkg::MODE_ARC_R;
        end
    end

    logic signed [15:0] r_out_left, r_out_right;
    dgp_pkg::t_mode     r_out_mode;
    logic               r_out_inpos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_left  <= n_left;
            r_out_right <= n_right;
            r_out_mode  <= n_mode;
            r_out_inpos <= r_f2_side.inpos;
        end
    end

    assign o_m_axis_tdata = {4'b0000, r_out_inpos, r_out_mode, r_out_right, r_out_left};

endmodule
